// File: rtl/ps2mct_pkg.sv
// Shared types and constants for the PS/2 mouse cursor tracker.
`default_nettype none
package ps2mct_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 12;
  localparam int unsigned OUT_W  = 12;
  localparam int unsigned ADDR_W = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam int unsigned SYNC_BIT = 3;

  localparam logic [CFG_W-1:0] X_MARGIN = 12'd40;
  localparam logic [CFG_W-1:0] Y_MARGIN = 12'd100;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd768;

  typedef enum logic [ADDR_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_START_X       = 2'd2,
    REG_START_Y       = 2'd3
  } cfg_reg_t;

endpackage
`default_nettype wire

// File: rtl/ps2_mouse_cursor_tracker.sv
// PS/2 mouse packet assembler with clamped cursor position tracking.
//
//  channel | ports                    | word
//  --------+--------------------------+---------------------------------------
//  in      | in_tvalid/tready/tdata   | [7:0] data_byte
//  out     | out_tvalid/tready/tdata  | [0] changed, [12:1] x_pos, [24:13] y_pos
//  cfg     | cfg_we/cfg_addr/cfg_wdata| 0 width, 1 height, 2 start_x, 3 start_y
//
// One word in per cycle while in_tready is high; its result shows on out in the cycle after acceptance.
// Packet state, cursor and the result register all update at the accept edge.
// in_tready is high while the result register is empty or being drained.
// Synchronous reset loads width 1024, height 768 and a cursor of zero.
`default_nettype none
module ps2_mouse_cursor_tracker #(
  parameter int unsigned POS_BITS = 12
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [ps2mct_pkg::IN_TDATA_W-1:0]       in_tdata,   // [7:0] data_byte
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic [ps2mct_pkg::OUT_TDATA_W-1:0]           out_tdata,  // changed, x_pos, y_pos
  input  wire logic                                    cfg_we,
  input  wire logic [ps2mct_pkg::ADDR_W-1:0]           cfg_addr,
  input  wire logic [ps2mct_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int unsigned SUM_W = ((POS_BITS > ps2mct_pkg::CFG_W) ?
                                   POS_BITS : ps2mct_pkg::CFG_W) + 2;
  localparam logic [SUM_W-1:0] PosMax = {{(SUM_W-POS_BITS){1'b0}}, {POS_BITS{1'b1}}};

  typedef enum logic [1:0] {
    IDX_STATUS = 2'd0,
    IDX_DX     = 2'd1,
    IDX_DY     = 2'd2
  } idx_t;

  idx_t                                idx_r, idx_nxt;
  logic [ps2mct_pkg::BYTE_W-1:0]       dx_r, dx_nxt;
  logic [POS_BITS-1:0]                 cx_r, cx_nxt;
  logic [POS_BITS-1:0]                 cy_r, cy_nxt;
  logic [ps2mct_pkg::CFG_W-1:0]        width_r, height_r;
  logic                                out_vld_r;
  logic                                chg_r, chg_nxt;
  logic [ps2mct_pkg::OUT_W-1:0]        xo_r, yo_r;
  logic [ps2mct_pkg::BYTE_W-1:0]       in_byte;
  logic [ps2mct_pkg::CFG_W-1:0]        lim_x12, lim_y12;
  logic [SUM_W-1:0]                    lim_x, lim_y;
  logic signed [SUM_W-1:0]             dx_ext, dy_ext;
  logic                                in_acc;

  function automatic logic [POS_BITS-1:0] axis_step(
    input logic [POS_BITS-1:0]    cur,
    input logic signed [SUM_W-1:0] delta,
    input logic [SUM_W-1:0]       lim
  );
    logic signed [SUM_W-1:0] sum;
    logic [POS_BITS-1:0]     res;
    sum = $signed({{(SUM_W-POS_BITS){1'b0}}, cur}) + delta;
    if (sum < 0) begin
      res = '0;
    end else if ($unsigned(sum) > lim) begin
      res = lim[POS_BITS-1:0];
    end else begin
      res = sum[POS_BITS-1:0];
    end
    return res;
  endfunction

  assign in_byte   = in_tdata[ps2mct_pkg::BYTE_W-1:0];
  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    lim_x12 = (width_r >= ps2mct_pkg::X_MARGIN) ? width_r - ps2mct_pkg::X_MARGIN : '0;
    lim_y12 = (height_r >= ps2mct_pkg::Y_MARGIN) ? height_r - ps2mct_pkg::Y_MARGIN : '0;
    lim_x   = SUM_W'(lim_x12);
    lim_y   = SUM_W'(lim_y12);
    if (lim_x > PosMax) begin
      lim_x = PosMax;
    end
    if (lim_y > PosMax) begin
      lim_y = PosMax;
    end
    dx_ext = $signed({{(SUM_W-ps2mct_pkg::BYTE_W){dx_r[ps2mct_pkg::BYTE_W-1]}}, dx_r});
    dy_ext = -$signed({{(SUM_W-ps2mct_pkg::BYTE_W){in_byte[ps2mct_pkg::BYTE_W-1]}},
                       in_byte});
  end

  always_comb begin
    idx_nxt = idx_r;
    dx_nxt  = dx_r;
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    chg_nxt = 1'b0;
    case (idx_r)
      IDX_STATUS: begin
        if (in_byte[ps2mct_pkg::SYNC_BIT]) begin
          idx_nxt = IDX_DX;
        end
      end
      IDX_DX: begin
        dx_nxt  = in_byte;
        idx_nxt = IDX_DY;
      end
      IDX_DY: begin
        idx_nxt = IDX_STATUS;
        chg_nxt = (dx_r != '0) || (in_byte != '0);
        if (dx_r != '0) begin
          cx_nxt = axis_step(cx_r, dx_ext, lim_x);
        end
        if (in_byte != '0) begin
          cy_nxt = axis_step(cy_r, dy_ext, lim_y);
        end
      end
      default: begin
        idx_nxt = IDX_STATUS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= IDX_STATUS;
      dx_r      <= '0;
      cx_r      <= '0;
      cy_r      <= '0;
      width_r   <= ps2mct_pkg::WIDTH_RST;
      height_r  <= ps2mct_pkg::HEIGHT_RST;
      out_vld_r <= 1'b0;
      chg_r     <= 1'b0;
      xo_r      <= '0;
      yo_r      <= '0;
    end else begin
      if (in_acc) begin
        idx_r     <= idx_nxt;
        dx_r      <= dx_nxt;
        chg_r     <= chg_nxt;
        xo_r      <= ps2mct_pkg::OUT_W'(cx_nxt);
        yo_r      <= ps2mct_pkg::OUT_W'(cy_nxt);
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we && (cfg_addr == ps2mct_pkg::REG_START_X)) begin
        cx_r <= POS_BITS'(cfg_wdata);
      end else if (in_acc) begin
        cx_r <= cx_nxt;
      end
      if (cfg_we && (cfg_addr == ps2mct_pkg::REG_START_Y)) begin
        cy_r <= POS_BITS'(cfg_wdata);
      end else if (in_acc) begin
        cy_r <= cy_nxt;
      end
      if (cfg_we) begin
        case (cfg_addr)
          ps2mct_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
          ps2mct_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(ps2mct_pkg::OUT_TDATA_W - 2*ps2mct_pkg::OUT_W - 1){1'b0}},
                       yo_r, xo_r, chg_r};

endmodule
`default_nettype wire

// File: rtl/ps2mct_checker.sv
// Port-level checker for the PS/2 mouse cursor tracker, bound to the top level.
`default_nettype none
module ps2mct_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [ps2mct_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out word valid right after reset");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted word produced no result");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while result register empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled out word changed or dropped");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_ps2mct_checker (.*);
`default_nettype wire
